@@ hw/rtl/single_bin_spectrum_magnitude_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the single-bin spectrum magnitude block
// ---------------------------------------------------------------------------
`ifndef SINGLE_BIN_SPECTRUM_MAGNITUDE_TOP_DEFINES_SVH
`define SINGLE_BIN_SPECTRUM_MAGNITUDE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define SBSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbsm port check failed");

// Check a consequence in the cycle after its cause
`define SBSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbsm port check failed");

`endif

@@ hw/rtl/sbsm_pkg.sv @@
// ---------------------------------------------------------------------------
// sbsm_pkg
// Shared constants, types and the phase table builder for the single-bin
// spectrum magnitude block.
// ---------------------------------------------------------------------------
package sbsm_pkg;

   localparam int PhaseSteps   = 2000;
   localparam int SampleBits   = 16;
   localparam int PhaseBits    = $clog2(PhaseSteps + 8);
   localparam int AddrBits     = $clog2(PhaseSteps);
   localparam int AccBits      = 44;
   localparam int ProdBits     = 32;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = 2;
   localparam int DivBits      = 56;
   localparam int DivisorBits  = 40;
   localparam int DivCntBits   = 6;

   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam longint unsigned OneQ30    = 64'd1 << 30;
   localparam longint unsigned SinDiv [8] = '{1, 6, 20, 42, 72, 110, 156, 210};
   localparam longint unsigned CosDiv [8] = '{1, 2, 12, 30, 56, 90, 132, 182};

   typedef logic [31:0] trig_rom_type [PhaseSteps];

   // one finished window on its way to the back end
   typedef struct packed {
      logic [AccBits-1:0] real_sum;
      logic [AccBits-1:0] imag_sum;
      logic [25:0]        scale;
   } window_type;

   typedef struct packed {
      logic                   start;
      logic [DivBits-1:0]     dividend;
      logic [DivisorBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DivBits-1:0] quotient;
   } div_rsp_type;

   // round a Q2.30 value to Q1.15, clamping to the positive range
   function automatic logic [15:0] to_q15(longint v);
      longint r;
      r = (v < 0) ? 64'sd0 : v;
      r = (r + 64'sd16384) >>> 15;
      if (r > 64'sd32767) r = 64'sd32767;
      return r[15:0];
   endfunction

   // cos and sin of 2*pi*p/PhaseSteps, packed as {cos, sin}
   function automatic logic [31:0] trig_entry(int unsigned p);
      longint unsigned q4, quad, rem, a, a2, ts, tc;
      longint          s, c;
      logic [15:0]     cq, sq, cv, sv;
      q4   = longint'(p) * 4;
      quad = q4 / PhaseSteps;
      rem  = q4 - quad * PhaseSteps;
      a    = (rem * HalfPiQ30) / PhaseSteps;
      a2   = (a * a) >> 30;
      ts   = a;
      tc   = OneQ30;
      s    = longint'(a);
      c    = longint'(OneQ30);
      for (int k = 1; k <= 7; k++) begin
         ts = ((ts * a2) >> 30) / SinDiv[k];
         tc = ((tc * a2) >> 30) / CosDiv[k];
         if (k % 2 == 1) begin
            s = s - longint'(ts);
            c = c - longint'(tc);
         end else begin
            s = s + longint'(ts);
            c = c + longint'(tc);
         end
      end
      cq = to_q15(c);
      sq = to_q15(s);
      case (quad[1:0])
         2'd0: begin
            cv = cq;
            sv = sq;
         end
         2'd1: begin
            cv = 16'd0 - sq;
            sv = cq;
         end
         2'd2: begin
            cv = 16'd0 - cq;
            sv = 16'd0 - sq;
         end
         default: begin
            cv = sq;
            sv = 16'd0 - cq;
         end
      endcase
      return {cv, sv};
   endfunction

   function automatic trig_rom_type build_trig_rom();
      trig_rom_type t;
      for (int p = 0; p < PhaseSteps; p++) begin
         t[p] = trig_entry(p);
      end
      return t;
   endfunction

endpackage

@@ hw/rtl/single_bin_spectrum_magnitude_top.sv @@
// ---------------------------------------------------------------------------
// single_bin_spectrum_magnitude_top
// Correlates a window of audio samples with one frequency bin and reports
// its scaled magnitude and sigmoid display level.
// ---------------------------------------------------------------------------
// Samples enter at one per cycle while the four-entry window queue has room;
// each sample runs through a two-stage table read and multiply before it is
// summed. Each window marked last is handed to the back end, which pops it,
// forms the sum of squares, the square root and the scaled magnitude, sets up
// the series, then runs twelve series terms and the final level, each of
// which waits on the shared 56-step divider, and loads the result. Windows
// that arrive faster than the back end drains them fill the queue, and
// req_ready then drops until the back end frees a slot.
module single_bin_spectrum_magnitude_top
   import sbsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample,
   input  logic [2:0]         req_window_periods,
   input  logic [25:0]        req_step_scale,
   input  logic               req_first,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_magnitude,
   output logic [15:0]        rsp_level
);

   logic                  push, pop;
   window_type            push_data, pop_data;
   logic [QueuePtrBits:0] queue_count;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   sbsm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_window_periods (req_window_periods),
      .req_step_scale     (req_step_scale),
      .req_first          (req_first),
      .req_last           (req_last),
      .queue_count        (queue_count),
      .push               (push),
      .push_data          (push_data)
   );

   sbsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (queue_count)
   );

   sbsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   sbsm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_count   (queue_count),
      .pop_data      (pop_data),
      .pop           (pop),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_magnitude (rsp_magnitude),
      .rsp_level     (rsp_level)
   );

endmodule

@@ hw/rtl/sbsm_front.sv @@
// ---------------------------------------------------------------------------
// sbsm_front
// Sample intake: phase tracking, phase table read, multiply and accumulate,
// and hand-off of each finished window to the queue.
// ---------------------------------------------------------------------------
module sbsm_front
   import sbsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_sample,
   input  logic [2:0]            req_window_periods,
   input  logic [25:0]           req_step_scale,
   input  logic                  req_first,
   input  logic                  req_last,
   input  logic [QueuePtrBits:0] queue_count,
   output logic                  push,
   output window_type            push_data
);

   localparam trig_rom_type TrigRom = build_trig_rom();

   logic                        accept;
   logic [PhaseBits-1:0]        phase_ff, phase_in, phase_use, phase_sum;
   logic [2:0]                  periods_ff, periods_use;
   logic [25:0]                 scale_ff, scale_use;
   logic signed [SampleBits-1:0] sample_use;
   logic [QueuePtrBits+1:0]     fill;

   // stage 1: table word and sample
   logic                         v1_ff, first1_ff, last1_ff;
   logic [25:0]                  scale1_ff;
   logic signed [SampleBits-1:0] sample1_ff;
   logic [31:0]                  rom_ff;
   logic signed [15:0]           cos1, sin1;

   // stage 2: products
   logic                        v2_ff, first2_ff, last2_ff;
   logic [25:0]                 scale2_ff;
   logic signed [ProdBits-1:0]  prod_re_ff, prod_re_in, prod_im_ff, prod_im_in;
   logic [AccBits-1:0]          real_ff, real_in, imag_ff, imag_in;

   // take a word only when every window in flight has a queue slot
   assign fill = (QueuePtrBits+2)'(queue_count) + (QueuePtrBits+2)'(last1_ff & v1_ff)
               + (QueuePtrBits+2)'(last2_ff & v2_ff);
   assign req_ready = (fill < (QueuePtrBits+2)'(QueueDepth));
   assign accept = req_valid && req_ready;

   // phase and held window settings
   always_comb begin
      phase_use   = req_first ? '0 : phase_ff;
      periods_use = req_first ? req_window_periods : periods_ff;
      scale_use   = req_first ? req_step_scale : scale_ff;
      phase_sum   = phase_use + PhaseBits'(periods_use);
      phase_in    = (phase_sum >= PhaseBits'(PhaseSteps)) ?
                    phase_sum - PhaseBits'(PhaseSteps) : phase_sum;
      sample_use  = req_sample[SampleBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         periods_ff <= 3'd1;
         scale_ff   <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         periods_ff <= periods_use;
         scale_ff   <= scale_use;
      end
   end

   // table read
   always_ff @(posedge clock) begin
      rom_ff <= TrigRom[phase_use[AddrBits-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   // advance payload along the pipe
   always_ff @(posedge clock) begin
      first1_ff  <= req_first;
      last1_ff   <= req_last;
      scale1_ff  <= scale_use;
      sample1_ff <= sample_use;
      first2_ff  <= first1_ff;
      last2_ff   <= last1_ff;
      scale2_ff  <= scale1_ff;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
   end

   // multiply sample by cos and sin
   always_comb begin
      cos1       = rom_ff[31:16];
      sin1       = rom_ff[15:0];
      prod_re_in = ProdBits'(sample1_ff) * ProdBits'(cos1);
      prod_im_in = ProdBits'(sample1_ff) * ProdBits'(sin1);
   end

   // accumulate, starting over on the first word of a window
   always_comb begin
      real_in = (first2_ff ? '0 : real_ff) + AccBits'(prod_re_ff);
      imag_in = (first2_ff ? '0 : imag_ff) + AccBits'(prod_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_ff <= '0;
         imag_ff <= '0;
      end else if (v2_ff) begin
         real_ff <= real_in;
         imag_ff <= imag_in;
      end
   end

   assign push               = v2_ff && last2_ff;
   assign push_data.real_sum = real_in;
   assign push_data.imag_sum = imag_in;
   assign push_data.scale    = scale2_ff;

endmodule

@@ hw/rtl/sbsm_queue.sv @@
// ---------------------------------------------------------------------------
// sbsm_queue
// Short queue of finished windows between the front and the back end.
// ---------------------------------------------------------------------------
module sbsm_queue
   import sbsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  window_type            push_data,
   input  logic                  pop,
   output window_type            pop_data,
   output logic [QueuePtrBits:0] count
);

   window_type                mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ff, rd_ff;
   logic [QueuePtrBits:0]     count_ff;

   // store incoming window
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   assign pop_data = mem_ff[rd_ff];
   assign count    = count_ff;

endmodule

@@ hw/rtl/sbsm_div.sv @@
// ---------------------------------------------------------------------------
// sbsm_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sbsm_div
   import sbsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                   busy_ff, done_ff;
   logic [DivCntBits-1:0]  cnt_ff;
   logic [DivBits-1:0]     dvd_ff;
   logic [DivisorBits-1:0] dsr_ff, rem_ff;
   logic [DivisorBits:0]   rem_sh;
   logic                   qbit;

   // trial subtract
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DivBits-1]};
      qbit   = (rem_sh >= {1'b0, dsr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DivCntBits'(DivBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift the dividend out and the quotient in
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DivBits-2:0], qbit};
         rem_ff <= qbit ? DivisorBits'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DivisorBits-1:0];
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

@@ hw/rtl/sbsm_back.sv @@
// ---------------------------------------------------------------------------
// sbsm_back
// Per-window back end: sum of squares, square root, scaling, sigmoid level
// and the result register.
// ---------------------------------------------------------------------------
module sbsm_back
   import sbsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [QueuePtrBits:0] queue_count,
   input  window_type            pop_data,
   output logic                  pop,
   output div_req_type           div_req,
   input  div_rsp_type           div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_magnitude,
   output logic [15:0]           rsp_level
);

   typedef enum logic [9:0] {
      ST_IDLE        = 10'b00_0000_0001,
      ST_SQUARE      = 10'b00_0000_0010,
      ST_ROOT        = 10'b00_0000_0100,
      ST_SCALE       = 10'b00_0000_1000,
      ST_EXPZ        = 10'b00_0001_0000,
      ST_EXPG        = 10'b00_0010_0000,
      ST_TERM_MUL    = 10'b00_0100_0000,
      ST_TERM_DIV    = 10'b00_1000_0000,
      ST_LEVEL_DIV   = 10'b01_0000_0000,
      ST_OUT         = 10'b10_0000_0000
   } back_state_type;

   localparam int SqBits = 88;

   back_state_type     state_ff, state_in;
   logic               div_pending_ff;
   logic [AccBits-1:0] mr_ff, mi_ff, op;
   logic [25:0]        scale_ff;
   logic [5:0]         cnt_ff;
   logic [SqBits-1:0]  acc_ff, acc_in, prod_ff, prod_in, rad_ff;
   logic [47:0]        rem_ff, rem_shift, trial;
   logic [43:0]        root_ff;
   logic [31:0]        mag_ff;
   logic [SqBits-1:0]  mag_tot;
   logic [59:0]        z_ff;
   logic [31:0]        g_ff, tmul_ff;
   logic [63:0]        g_prod;
   logic [64:0]        t_prod;
   logic [32:0]        term_ff;
   logic signed [35:0] ser_ff;
   logic [3:0]         k_ff;
   logic [15:0]        level_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_magnitude_ff;
   logic [15:0]        rsp_level_ff;
   logic [25:0]        mul_a;
   logic [21:0]        mul_b;
   logic [5:0]         mul_shift;
   logic [47:0]        mul_p;
   logic [32:0]        ser_clamp, e_val, num;
   logic [33:0]        den;
   logic [11:0]        exp_n;
   logic               load_out;

   // shared multiplier for squares and scaling
   always_comb begin
      op        = (cnt_ff < 6'd3) ? mr_ff : mi_ff;
      mul_a     = '0;
      mul_b     = '0;
      mul_shift = 6'd0;
      if (state_ff == ST_SCALE) begin
         mul_a     = scale_ff;
         mul_b     = (cnt_ff == 6'd0) ? root_ff[21:0] : root_ff[43:22];
         mul_shift = (cnt_ff == 6'd0) ? 6'd0 : 6'd22;
      end else begin
         case (cnt_ff) inside
            6'd0, 6'd3: begin
               mul_a     = 26'(op[21:0]);
               mul_b     = op[21:0];
               mul_shift = 6'd0;
            end
            6'd1, 6'd4: begin
               mul_a     = 26'(op[21:0]);
               mul_b     = op[43:22];
               mul_shift = 6'd23;
            end
            default: begin
               mul_a     = 26'(op[43:22]);
               mul_b     = op[43:22];
               mul_shift = 6'd44;
            end
         endcase
      end
      mul_p   = 48'(mul_a) * 48'(mul_b);
      prod_in = SqBits'(mul_p) << mul_shift;
      acc_in  = (cnt_ff == 6'd0) ? acc_ff : acc_ff + prod_ff;
      mag_tot = acc_in + (SqBits'(1) << 38);
   end

   // one bit of the square root
   always_comb begin
      rem_shift = {rem_ff[45:0], rad_ff[SqBits-1:SqBits-2]};
      trial     = {2'b00, root_ff, 2'b01};
   end

   // level operands
   always_comb begin
      g_prod    = 64'(z_ff[47:16]) * 64'(32'd2977044472);
      t_prod    = 65'(term_ff) * 65'(g_ff);
      exp_n     = z_ff[59:48];
      if (ser_ff < 36'sd0)                   ser_clamp = '0;
      else if (ser_ff > 36'sh1_0000_0000)    ser_clamp = 33'h1_0000_0000;
      else                                   ser_clamp = ser_ff[32:0];
      e_val     = (exp_n > 12'd32) ? '0 : ser_clamp >> exp_n[5:0];
      num       = 33'h1_0000_0000 - e_val;
      den       = 34'h1_0000_0000 + 34'(e_val);
   end

   // divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      if (state_ff == ST_TERM_DIV && !div_pending_ff) begin
         div_req.start    = 1'b1;
         div_req.dividend = DivBits'(tmul_ff);
         div_req.divisor  = DivisorBits'(k_ff);
      end else if (state_ff == ST_LEVEL_DIV && !div_pending_ff) begin
         div_req.start    = 1'b1;
         div_req.dividend = DivBits'(num) * DivBits'(917504) + DivBits'(den) * DivBits'(10);
         div_req.divisor  = DivisorBits'(den) * DivisorBits'(20);
      end
   end

   assign pop      = (state_ff == ST_IDLE) && (queue_count != '0);
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (pop) state_in = ST_SQUARE;
         ST_SQUARE:    if (cnt_ff == 6'd6) state_in = ST_ROOT;
         ST_ROOT:      if (cnt_ff == 6'd43) state_in = ST_SCALE;
         ST_SCALE:     if (cnt_ff == 6'd2) state_in = ST_EXPZ;
         ST_EXPZ:      state_in = ST_EXPG;
         ST_EXPG:      state_in = ST_TERM_MUL;
         ST_TERM_MUL:  state_in = ST_TERM_DIV;
         ST_TERM_DIV: begin
            if (div_pending_ff && div_rsp.done) begin
               state_in = (k_ff == 4'd12) ? ST_LEVEL_DIV : ST_TERM_MUL;
            end
         end
         ST_LEVEL_DIV: if (div_pending_ff && div_rsp.done) state_in = ST_OUT;
         ST_OUT:       if (load_out) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         div_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_req.start)     div_pending_ff <= 1'b1;
         else if (div_rsp.done) div_pending_ff <= 1'b0;
         if (load_out)          rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (state_ff)
         ST_IDLE: begin
            mr_ff    <= pop_data.real_sum[AccBits-1] ? AccBits'(0) - pop_data.real_sum
                                                     : pop_data.real_sum;
            mi_ff    <= pop_data.imag_sum[AccBits-1] ? AccBits'(0) - pop_data.imag_sum
                                                     : pop_data.imag_sum;
            scale_ff <= pop_data.scale;
            acc_ff   <= '0;
            cnt_ff   <= '0;
         end
         ST_SQUARE: begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'd6) begin
               rad_ff  <= acc_in;
               rem_ff  <= '0;
               root_ff <= '0;
               cnt_ff  <= '0;
            end
         end
         ST_ROOT: begin
            rad_ff <= {rad_ff[SqBits-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_ff  <= rem_shift - trial;
               root_ff <= {root_ff[42:0], 1'b1};
            end else begin
               rem_ff  <= rem_shift;
               root_ff <= {root_ff[42:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'd43) begin
               cnt_ff <= '0;
               acc_ff <= '0;
            end
         end
         ST_SCALE: begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'd2) begin
               mag_ff <= (|mag_tot[SqBits-1:71]) ? 32'hFFFF_FFFF : mag_tot[70:39];
            end
         end
         ST_EXPZ: begin
            z_ff <= 60'(mag_ff) * 60'(28'd206544267);
         end
         ST_EXPG: begin
            g_ff    <= g_prod[63:32];
            term_ff <= 33'h1_0000_0000;
            ser_ff  <= 36'sh1_0000_0000;
            k_ff    <= 4'd1;
         end
         ST_TERM_MUL: begin
            tmul_ff <= t_prod[63:32];
         end
         ST_TERM_DIV: begin
            if (div_pending_ff && div_rsp.done) begin
               term_ff <= div_rsp.quotient[32:0];
               if (k_ff[0]) ser_ff <= ser_ff - $signed(36'(div_rsp.quotient[32:0]));
               else         ser_ff <= ser_ff + $signed(36'(div_rsp.quotient[32:0]));
               k_ff <= k_ff + 1'b1;
            end
         end
         ST_LEVEL_DIV: begin
            if (div_pending_ff && div_rsp.done) level_ff <= div_rsp.quotient[15:0];
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_magnitude_ff <= mag_ff;
               rsp_level_ff     <= level_ff;
            end
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;
   assign rsp_level     = rsp_level_ff;

endmodule

@@ hw/rtl/sbsm_checker.sv @@
// ---------------------------------------------------------------------------
// sbsm_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "single_bin_spectrum_magnitude_top_defines.svh"

module sbsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [31:0]        rsp_magnitude,
   input logic [15:0]        rsp_level
);

   // hold a stalled result
   `SBSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SBSM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_magnitude) && $stable(rsp_level))
   // level stays below its sigmoid ceiling
   `SBSM_ASSERT_NOW(a_level_max, clock, reset, rsp_valid, rsp_level <= 16'd45875)
   // silent window gives a zero level
   `SBSM_ASSERT_NOW(a_level_zero, clock, reset, rsp_valid && rsp_magnitude == 32'd0, rsp_level == 16'd0)

endmodule

bind single_bin_spectrum_magnitude_top sbsm_checker u_checker (.*);

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// Single-bin spectrum magnitude testbench
// Streams sample words with random gaps and backpressure, keeps its own
// correlation sums, square root and sigmoid level, and compares each window
// result word with the oldest one it predicted.
// ---------------------------------------------------------------------------
module tb_top;
   import sbsm_pkg::*;

   localparam int unsigned Steps   = 2000;
   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam longint unsigned Q32 = 64'd1 << 32;

   typedef struct packed {
      logic [31:0] mag;
      logic [15:0] lvl;
   } bin_result_type;

   typedef struct packed {
      logic [15:0] sample;
      logic [2:0]  periods;
      logic [25:0] scale;
      logic        first;
      logic        last;
      logic        typed;
      logic [31:0] mag;
      logic [15:0] lvl;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = '0;
   logic [2:0]         req_window_periods = 3'd1;
   logic [25:0]        req_step_scale = '0;
   logic               req_first = 1'b0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_magnitude;
   logic [15:0]        rsp_level;

   // predictor state
   logic [43:0]  sum_re, sum_im;
   int unsigned  phase;
   logic [2:0]   periods_q;
   logic [25:0]  scale_q;
   logic [15:0]  cos_tab [Steps];
   logic [15:0]  sin_tab [Steps];

   bin_result_type expected_q [$];
   int             errors = 0;
   bit             gaps_on = 1'b1;

   single_bin_spectrum_magnitude_top u_dut (.*);

   always #5 clock = ~clock;

   // round Q2.30 to Q1.15, clamp to [0, 32767]
   function automatic logic [15:0] round_q15(longint v);
      longint r;
      r = (v < 0) ? 0 : v;
      r = (r + 16384) / 32768;
      if (r > 32767) r = 32767;
      return r[15:0];
   endfunction

   // fill the cos/sin table by quadrant folding and a Taylor series
   task automatic build_phase_table();
      longint unsigned q4, quad, rem, ang, ang2, ts, tc;
      longint          s, c;
      logic [15:0]     cq, sq;
      for (int p = 0; p < Steps; p++) begin
         q4   = 64'(p) * 4;
         quad = q4 / Steps;
         rem  = q4 - quad * Steps;
         ang  = (rem * 64'd1686629713) / Steps;
         ang2 = (ang * ang) >> 30;
         ts = ang;
         tc = Q30;
         s  = longint'(ang);
         c  = longint'(Q30);
         for (int k = 1; k <= 7; k++) begin
            ts = ((ts * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
            tc = ((tc * ang2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2) begin
               s -= longint'(ts);
               c -= longint'(tc);
            end else begin
               s += longint'(ts);
               c += longint'(tc);
            end
         end
         cq = round_q15(c);
         sq = round_q15(s);
         case (quad[1:0])
            2'd0: begin cos_tab[p] = cq;         sin_tab[p] = sq;         end
            2'd1: begin cos_tab[p] = 16'd0 - sq; sin_tab[p] = cq;         end
            2'd2: begin cos_tab[p] = 16'd0 - cq; sin_tab[p] = 16'd0 - sq; end
            default: begin cos_tab[p] = sq;      sin_tab[p] = 16'd0 - cq; end
         endcase
      end
   endtask

   function automatic logic [43:0] abs44(logic [43:0] v);
      return v[43] ? (44'd0 - v) : v;
   endfunction

   // scaled magnitude of the present sums
   function automatic logic [31:0] window_mag();
      logic [127:0] mr, mi, nsq, r, t, prod;
      mr  = 128'(abs44(sum_re));
      mi  = 128'(abs44(sum_im));
      nsq = mr * mr + mi * mi;
      r   = '0;
      for (int b = 44; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= nsq) r = t;
      end
      prod = (128'(scale_q) * r + (128'd1 << 38)) >> 39;
      return (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   // sigmoid display level of a magnitude
   function automatic logic [15:0] sigmoid_level(logic [31:0] mag);
      longint unsigned z, n, f, g, term, e, num, den, lv;
      longint          acc;
      z = 64'(mag) * 64'd206544267;
      n = z >> 48;
      f = (z >> 16) & 64'hFFFF_FFFF;
      g = (f * 64'd2977044472) >> 32;
      term = Q32;
      acc  = longint'(Q32);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * g) >> 32) / longint'(k);
         if (k % 2) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(Q32)) acc = longint'(Q32);
      e   = (n > 32) ? 0 : (longint'(acc) >> n);
      num = Q32 - e;
      den = Q32 + e;
      lv  = (64'd7 * num * 64'd131072 + 64'd10 * den) / (64'd20 * den);
      return lv[15:0];
   endfunction

   // advance the sums by one sample; return 1 and the result on a last word
   function automatic bit correlate_sample(logic [15:0] smp, logic [2:0] per,
                                           logic [25:0] scl, logic fst,
                                           logic lst, output bin_result_type res);
      logic signed [31:0] pc, ps;
      if (fst) begin
         sum_re    = '0;
         sum_im    = '0;
         phase     = 0;
         periods_q = per;
         scale_q   = scl;
      end
      pc = $signed(smp) * $signed(cos_tab[phase]);
      ps = $signed(smp) * $signed(sin_tab[phase]);
      sum_re = sum_re + 44'($signed(pc));
      sum_im = sum_im + 44'($signed(ps));
      phase += periods_q;
      if (phase >= Steps) phase -= Steps;
      res.mag = window_mag();
      res.lvl = sigmoid_level(res.mag);
      return lst;
   endfunction

   // drive one word, wait for acceptance, record its result if any
   task automatic send_word(logic [15:0] smp, logic [2:0] per, logic [25:0] scl,
                            logic fst, logic lst, bit typed = 0,
                            bin_result_type typed_res = '0);
      bin_result_type res;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= smp;
      req_window_periods <= per;
      req_step_scale     <= scl;
      req_first          <= fst;
      req_last           <= lst;
      do @(posedge clock); while (!req_ready);
      if (correlate_sample(smp, per, scl, fst, lst, res))
         expected_q.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   function automatic logic [2:0] pick_periods();
      case ($urandom_range(0, 9))
         0: return 3'($urandom_range(0, 7));
         1, 2, 3: return 3'd1;
         4, 5, 6: return 3'd2;
         default: return 3'd4;
      endcase
   endfunction

   // one window; noise drops the first flag or adds stray flags
   task automatic send_window(int len, logic [2:0] per, bit noisy);
      logic [25:0] scl;
      logic        fst, lst;
      scl = ($urandom_range(0, 7) == 0) ? 26'h3FF_FFFF : 26'($urandom());
      for (int i = 0; i < len; i++) begin
         fst = (i == 0);
         lst = (i == len - 1);
         if (noisy) begin
            if ($urandom_range(0, 9) == 0) fst = ~fst;
            if ($urandom_range(0, 19) == 0) lst = 1'b1;
         end
         send_word(16'($urandom()), per, scl, fst, lst);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   stim_row_type directed [] = '{
      // zero sample, full scale: zero magnitude and level
      '{16'h0000, 3'd1, 26'h3FF_FFFF, 1, 1, 1, 32'd0, 16'd0},
      // full sample, zero scale
      '{16'h7FFF, 3'd1, 26'h000_0000, 1, 1, 1, 32'd0, 16'd0},
      '{16'h8000, 3'd4, 26'h3FF_FFFF, 1, 1, 0, 32'd0, 16'd0},
      '{16'h04D2, 3'd2, 26'h000_3039, 1, 0, 0, 32'd0, 16'd0},
      '{16'hFFFF, 3'd2, 26'h000_0000, 0, 0, 0, 32'd0, 16'd0},
      '{16'h7FFF, 3'd2, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      // no first after last: keeps summing
      '{16'h01F4, 3'd0, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      // periods zero holds phase
      '{16'h8000, 3'd0, 26'h3FF_FFFF, 1, 0, 0, 32'd0, 16'd0},
      '{16'h8000, 3'd0, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      '{16'h0064, 3'd7, 26'h3FF_FFFF, 1, 0, 0, 32'd0, 16'd0},
      '{16'h7FFF, 3'd0, 26'h000_0000, 0, 0, 0, 32'd0, 16'd0},
      '{16'h8000, 3'd0, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      '{16'h5555, 3'd3, 26'h2AA_AAAA, 1, 0, 0, 32'd0, 16'd0},
      '{16'hAAAA, 3'd0, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      '{16'h1234, 3'd5, 26'h155_5555, 1, 0, 0, 32'd0, 16'd0},
      '{16'hEDCB, 3'd0, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0},
      '{16'h7FFF, 3'd6, 26'h3FF_FFFF, 1, 0, 0, 32'd0, 16'd0},
      '{16'h7FFF, 3'd1, 26'h000_0000, 0, 1, 0, 32'd0, 16'd0}
   };

   // stimulus
   initial begin
      int sent;
      int len;
      build_phase_table();
      sum_re = '0; sum_im = '0; phase = 0; periods_q = 3'd1; scale_q = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table
      foreach (directed[i])
         send_word(directed[i].sample, directed[i].periods, directed[i].scale,
                   directed[i].first, directed[i].last, directed[i].typed,
                   '{directed[i].mag, directed[i].lvl});

      // hold the sender until every result is back
      wait_drained();

      // window long enough to wrap the phase table
      send_window(520, 3'd4, 0);

      // random windows, mostly short
      sent = 0;
      while (sent < 1400) begin
         if (sent > 1100) gaps_on = 1'b0;
         case ($urandom_range(0, 19))
            0: len = $urandom_range(100, 300);
            default: len = $urandom_range(1, 40);
         endcase
         send_window(len, pick_periods(), $urandom_range(0, 4) == 0);
         sent += len;
      end

      wait_drained();
      repeat (1000) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // result side backpressure in random bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      bin_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result mag=%0d lvl=%0d", $realtime,
                     rsp_magnitude, rsp_level);
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_magnitude !== exp_r.mag) begin
               $display("%0t: magnitude expected %0d actual %0d", $realtime,
                        exp_r.mag, rsp_magnitude);
               errors++;
            end
            if (rsp_level !== exp_r.lvl) begin
               $display("%0t: level expected %0d actual %0d", $realtime,
                        exp_r.lvl, rsp_level);
               errors++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #100000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
